// ----- rtl/isots_pkg.sv -----
// Package for the ISO-8601 timestamp parser: record types, character and
// error codes, and the day-of-year table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package isots_pkg;

    localparam int ISOTS_QUEUE_DEPTH = 2;
    localparam int LOCAL_OFFSET_W    = 12;
    localparam int TDATA_IN_W        = 8;
    localparam int TDATA_OUT_W       = 112;

    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_DATE   = 3'd1;
    localparam logic [2:0] ERR_SEP    = 3'd2;
    localparam logic [2:0] ERR_TIME   = 3'd3;
    localparam logic [2:0] ERR_SUFFIX = 3'd4;

    localparam logic [1:0] SUF_NONE  = 2'd0;
    localparam logic [1:0] SUF_Z     = 2'd1;
    localparam logic [1:0] SUF_PLUS  = 2'd2;
    localparam logic [1:0] SUF_MINUS = 2'd3;

    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    // one parsed string, handed from the front end to the back end
    typedef struct packed {
        logic [2:0]  error;
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [1:0]  suffix;
        logic [6:0]  zone_hour;
        logic [6:0]  zone_minute;
    } isots_rec_t;

    // result transaction, lowest field last so it maps onto m_tdata
    typedef struct packed {
        logic [4:0]         pad;
        logic signed [38:0] unix_seconds;
        logic signed [13:0] zone_minutes;
        logic               is_utc;
        logic               offset_present;
        logic [6:0]         second_value;
        logic [6:0]         minute_value;
        logic [6:0]         hour_value;
        logic [6:0]         day_value;
        logic [6:0]         month_value;
        logic [13:0]        year_value;
        logic [2:0]         error_code;
    } isots_res_t;

    // days from March 1 to the first of the month, month index 0 = March
    function automatic logic [8:0] month_start_doy(input logic [3:0] mm);
        logic [8:0] r;
        case (mm)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/isots_front.sv -----
// Character front end: checks the grammar one character per cycle while the queue has
// room, and accumulates the fields. Depends on isots_pkg.
`timescale 1ns / 1ps
`default_nettype none

module isots_front import isots_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,   // [7:0] text_byte
    input  wire logic             s_tlast,   // last_byte
    output logic                  push_valid,
    input  wire logic             push_ready,
    output isots_rec_t            push_data
);

    logic [4:0] pos_reg;
    logic [2:0] err_reg, err_next;
    logic [1:0] suffix_reg, suffix_next;
    logic [13:0] year_reg, year_next;
    logic [6:0] month_reg, month_next, day_reg, day_next;
    logic [6:0] hour_reg, hour_next, minute_reg, minute_next, second_reg, second_next;
    logic [6:0] zh_reg, zh_next, zm_reg, zm_next;
    logic       is_dig;
    logic [3:0] dval;
    logic [5:0] len;
    logic [2:0] fin_err;
    logic       accept;

    assign s_tready   = push_ready;
    assign push_valid = s_tvalid && s_tlast;
    assign accept     = s_tvalid && push_ready;
    assign is_dig     = (s_tdata >= CH_0) && (s_tdata <= CH_9);
    assign dval       = 4'(s_tdata - CH_0);
    assign len        = 6'(pos_reg) + 6'd1;

    always_comb begin
        err_next    = err_reg;
        suffix_next = suffix_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        zh_next     = zh_reg;
        zm_next     = zm_reg;
        if (err_reg == ERR_NONE) begin
            case (pos_reg)
                5'd0, 5'd1, 5'd2, 5'd3: begin
                    if (is_dig) year_next = 14'(year_reg * 14'd10 + 14'(dval));
                    else err_next = ERR_DATE;
                end
                5'd4, 5'd7: begin
                    if (s_tdata != CH_DASH) err_next = ERR_DATE;
                end
                5'd5, 5'd6: begin
                    if (is_dig) month_next = 7'(month_reg * 7'd10 + 7'(dval));
                    else err_next = ERR_DATE;
                end
                5'd8, 5'd9: begin
                    if (is_dig) day_next = 7'(day_reg * 7'd10 + 7'(dval));
                    else err_next = ERR_DATE;
                end
                5'd10: begin
                    if (s_tdata != CH_T && s_tdata != CH_SPACE) err_next = ERR_SEP;
                end
                5'd11, 5'd12: begin
                    if (is_dig) hour_next = 7'(hour_reg * 7'd10 + 7'(dval));
                    else err_next = ERR_TIME;
                end
                5'd13, 5'd16: begin
                    if (s_tdata != CH_COLON) err_next = ERR_TIME;
                end
                5'd14, 5'd15: begin
                    if (is_dig) minute_next = 7'(minute_reg * 7'd10 + 7'(dval));
                    else err_next = ERR_TIME;
                end
                5'd17, 5'd18: begin
                    if (is_dig) second_next = 7'(second_reg * 7'd10 + 7'(dval));
                    else err_next = ERR_TIME;
                end
                5'd19: begin
                    if (s_tdata == CH_Z) suffix_next = SUF_Z;
                    else if (s_tdata == CH_PLUS) suffix_next = SUF_PLUS;
                    else if (s_tdata == CH_DASH) suffix_next = SUF_MINUS;
                    else err_next = ERR_SUFFIX;
                end
                5'd20, 5'd21: begin
                    if (suffix_reg < SUF_PLUS) err_next = ERR_SUFFIX;
                    else if (is_dig) zh_next = 7'(zh_reg * 7'd10 + 7'(dval));
                    else err_next = ERR_SUFFIX;
                end
                5'd22: begin
                    if (suffix_reg < SUF_PLUS || s_tdata != CH_COLON) err_next = ERR_SUFFIX;
                end
                5'd23, 5'd24: begin
                    if (suffix_reg < SUF_PLUS) err_next = ERR_SUFFIX;
                    else if (is_dig) zm_next = 7'(zm_reg * 7'd10 + 7'(dval));
                    else err_next = ERR_SUFFIX;
                end
                default: err_next = ERR_SUFFIX;
            endcase
        end
    end

    // length checks at the end of the string
    always_comb begin
        fin_err = err_next;
        if (err_next == ERR_NONE) begin
            if (len < 6'd10) fin_err = ERR_DATE;
            else if (len >= 6'd11 && len <= 6'd18) fin_err = ERR_TIME;
            else if (len >= 6'd20 && len <= 6'd24 && suffix_next >= SUF_PLUS)
                fin_err = ERR_SUFFIX;
        end
    end

    always_comb begin
        push_data.error       = fin_err;
        push_data.year        = year_next;
        push_data.month       = month_next;
        push_data.day         = day_next;
        push_data.hour        = hour_next;
        push_data.minute      = minute_next;
        push_data.second      = second_next;
        push_data.suffix      = suffix_next;
        push_data.zone_hour   = zh_next;
        push_data.zone_minute = zm_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_tlast)) begin
            pos_reg    <= '0;
            err_reg    <= ERR_NONE;
            suffix_reg <= SUF_NONE;
            year_reg   <= '0;
            month_reg  <= '0;
            day_reg    <= '0;
            hour_reg   <= '0;
            minute_reg <= '0;
            second_reg <= '0;
            zh_reg     <= '0;
            zm_reg     <= '0;
        end else if (accept) begin
            if (pos_reg < 5'd26) pos_reg <= pos_reg + 5'd1;
            err_reg    <= err_next;
            suffix_reg <= suffix_next;
            year_reg   <= year_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
            zh_reg     <= zh_next;
            zm_reg     <= zm_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/isots_queue.sv -----
// Small register queue of parsed strings between front and back end.
// Depends on isots_pkg.
`timescale 1ns / 1ps
`default_nettype none

module isots_queue import isots_pkg::*; #(
    parameter int DEPTH = ISOTS_QUEUE_DEPTH
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push_valid,
    output logic            push_ready,
    input  wire isots_rec_t push_data,
    output logic            pop_valid,
    input  wire logic       pop_ready,
    output isots_rec_t      pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    isots_rec_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop) rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (do_push && !do_pop) count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push) count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/isots_back.sv -----
// Back end: converts one parsed string to Unix time in a short sequence
// of steps and holds the result transaction. Depends on isots_pkg.
`timescale 1ns / 1ps
`default_nettype none

module isots_back import isots_pkg::*; (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wr_en,
    input  wire logic [LOCAL_OFFSET_W-1:0] cfg_wr_data,
    input  wire logic                      pop_valid,
    output logic                           pop_ready,
    input  wire isots_rec_t                pop_data,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [TDATA_OUT_W-1:0]         m_tdata
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MONTH = 4'd1;
    localparam logic [3:0] ST_ERA   = 4'd2;
    localparam logic [3:0] ST_YOE   = 4'd3;
    localparam logic [3:0] ST_DOE   = 4'd4;
    localparam logic [3:0] ST_DAYS  = 4'd5;
    localparam logic [3:0] ST_MUL   = 4'd6;
    localparam logic [3:0] ST_SUM   = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    logic [3:0] state_reg;
    logic signed [LOCAL_OFFSET_W-1:0] local_off_reg;
    isots_rec_t rec_reg;

    logic signed [14:0] y_reg;
    logic [3:0]         mm_reg;
    logic signed [13:0] zone_reg, off_reg;
    logic signed [5:0]  era_reg;
    logic [8:0]         yoe_reg;
    logic signed [23:0] era_days_reg;
    logic [17:0]        doe_reg;
    logic signed [23:0] days_reg;
    logic signed [21:0] tod_reg;
    logic signed [40:0] prod_reg;
    logic signed [38:0] secs_reg;
    logic               m_tvalid_reg;
    isots_res_t         res_reg;

    // month normalization, zone, era, century and time-of-day terms
    logic [6:0]         mi_u;
    logic [14:0]        q_prod;
    logic [3:0]         q;
    logic [6:0]         rem;
    logic [3:0]         mnorm;
    logic signed [4:0]  yadj;
    logic signed [14:0] y_next;
    logic [3:0]         mm_next;
    logic [13:0]        zmag;
    logic signed [13:0] zone_next;
    logic [26:0]        era_prod;
    logic [1:0]         cent;
    logic [21:0]        tod_pos;
    logic               out_free;
    isots_res_t         res_next;

    assign pop_ready = state_reg == ST_IDLE;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = res_reg;

    always_comb begin
        mi_u   = rec_reg.month - 7'd1;
        q_prod = 15'(mi_u) * 15'd171;
        q      = q_prod[14:11];
        rem    = 7'(mi_u - 7'(q) * 7'd12);
        if (rec_reg.month == 7'd0) begin
            yadj  = -5'sd1;
            mnorm = 4'd12;
        end else begin
            yadj  = $signed({1'b0, q});
            mnorm = 4'(rem) + 4'd1;
        end
        y_next  = $signed({1'b0, rec_reg.year}) + 15'(yadj)
                - ((mnorm <= 4'd2) ? 15'sd1 : 15'sd0);
        mm_next = (mnorm > 4'd2) ? mnorm - 4'd3 : mnorm + 4'd9;
        zmag    = 14'(rec_reg.zone_hour) * 14'd60 + 14'(rec_reg.zone_minute);
        if (rec_reg.suffix == SUF_MINUS) zone_next = -$signed(zmag);
        else if (rec_reg.suffix == SUF_PLUS) zone_next = $signed(zmag);
        else zone_next = '0;
        era_prod = 27'(y_reg[13:0]) * 27'd5243;
        if (yoe_reg >= 9'd300) cent = 2'd3;
        else if (yoe_reg >= 9'd200) cent = 2'd2;
        else if (yoe_reg >= 9'd100) cent = 2'd1;
        else cent = 2'd0;
        tod_pos = 22'(rec_reg.hour) * 22'd3600 + 22'(rec_reg.minute) * 22'd60
                + 22'(rec_reg.second);
    end

    always_comb begin
        res_next     = '0;
        res_next.error_code = rec_reg.error;
        if (rec_reg.error == ERR_NONE) begin
            res_next.year_value     = rec_reg.year;
            res_next.month_value    = rec_reg.month;
            res_next.day_value      = rec_reg.day;
            res_next.hour_value     = rec_reg.hour;
            res_next.minute_value   = rec_reg.minute;
            res_next.second_value   = rec_reg.second;
            res_next.offset_present = rec_reg.suffix != SUF_NONE;
            res_next.is_utc         = rec_reg.suffix == SUF_Z;
            res_next.zone_minutes   = zone_reg;
            res_next.unix_seconds   = secs_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) local_off_reg <= '0;
        else if (cfg_wr_en) local_off_reg <= $signed(cfg_wr_data);
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (pop_valid) rec_reg <= pop_data;
            end
            ST_MONTH: begin
                y_reg    <= y_next;
                mm_reg   <= mm_next;
                zone_reg <= zone_next;
                off_reg  <= (rec_reg.suffix != SUF_NONE) ? zone_next : 14'(local_off_reg);
            end
            ST_ERA: begin
                era_reg <= (y_reg < 0) ? -6'sd1 : $signed({1'b0, era_prod[25:21]});
            end
            ST_YOE: begin
                yoe_reg      <= 9'(y_reg - 15'(era_reg) * 15'sd400);
                era_days_reg <= 24'(era_reg) * 24'sd146097;
            end
            ST_DOE: begin
                doe_reg <= 18'(yoe_reg) * 18'd365 + 18'(yoe_reg[8:2]) - 18'(cent)
                         + 18'(month_start_doy(mm_reg));
            end
            ST_DAYS: begin
                days_reg <= era_days_reg + $signed({6'b0, doe_reg}) - 24'sd719468
                          + $signed({17'b0, rec_reg.day}) - 24'sd1;
                tod_reg  <= $signed(tod_pos) - 22'(off_reg) * 22'sd60;
            end
            ST_MUL: begin
                prod_reg <= 41'(days_reg) * 41'sd86400;
            end
            ST_SUM: begin
                secs_reg <= 39'(prod_reg + 41'(tod_reg));
            end
            ST_OUT: begin
                if (out_free) res_reg <= res_next;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_OUT && out_free) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (pop_valid)
                        state_reg <= (pop_data.error != ERR_NONE) ? ST_OUT : ST_MONTH;
                end
                ST_MONTH: state_reg <= ST_ERA;
                ST_ERA:   state_reg <= ST_YOE;
                ST_YOE:   state_reg <= ST_DOE;
                ST_DOE:   state_reg <= ST_DAYS;
                ST_DAYS:  state_reg <= ST_MUL;
                ST_MUL:   state_reg <= ST_SUM;
                ST_SUM:   state_reg <= ST_OUT;
                ST_OUT: begin
                    if (out_free) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/iso8601_timestamp_parser_core.sv -----
// Top level of the ISO-8601 timestamp parser: front end, queue, back end.
// Depends on isots_pkg, isots_front, isots_queue, isots_back.
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tdata = text_byte, s_tlast = last_byte
// m_*       out  m_tvalid/m_tready  m_tdata = one result per string
// cfg_*     in   cfg_wr_en          cfg_wr_data = local_offset_minutes
//
// Characters are taken one per cycle while the queue has a free slot
// (QUEUE_DEPTH strings); a full queue holds s_tready low.
// Conversion steps the back end through IDLE, MONTH, ERA, YOE, DOE, DAYS, MUL, SUM, OUT,
// then the output handoff; an errored string skips to OUT. The back end sets the string rate.
// Reset (synchronous, aresetn low) clears parser state, queue and output.
`timescale 1ns / 1ps
`default_nettype none

module iso8601_timestamp_parser_core import isots_pkg::*; #(
    parameter int QUEUE_DEPTH = ISOTS_QUEUE_DEPTH
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_wr_en,
    input  wire logic [LOCAL_OFFSET_W-1:0] cfg_wr_data,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [TDATA_IN_W-1:0]     s_tdata,   // [7:0] text_byte
    input  wire logic                      s_tlast,   // last_byte
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // [2:0] error_code, [16:3] year_value, [23:17] month_value,
    // [30:24] day_value, [37:31] hour_value, [44:38] minute_value,
    // [51:45] second_value, [52] offset_present, [53] is_utc,
    // [67:54] zone_minutes, [106:68] unix_seconds, [111:107] zero
    output logic [TDATA_OUT_W-1:0]         m_tdata
);

    logic       push_valid, push_ready, pop_valid, pop_ready;
    isots_rec_t push_data, pop_data;

    isots_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    isots_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    isots_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

`default_nettype wire
